[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the cellular automaton classifier.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/eca_pkg.sv]
// Shared types and constants of the elementary cellular automaton classifier.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
`default_nettype none

package eca_pkg;

  localparam int unsigned CELLS_DEF = 32;
  localparam int unsigned STEPS_DEF = 32;

  localparam int unsigned PATTERN_W = 32;
  localparam int unsigned RULE_W    = 8;
  localparam int unsigned MODE_W    = 2;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_XOR   = 2'd0;
  localparam mode_t MODE_CELL0 = 2'd1;
  localparam mode_t MODE_RESET = 2'd2;

  // What every cell of the ring does in a cycle.
  typedef logic [1:0] cell_op_t;

  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_LOAD = 2'd1;
  localparam cell_op_t OP_GEN  = 2'd2;
  localparam cell_op_t OP_ROT  = 2'd3;

  typedef struct packed {
    cell_op_t          op;
    logic [RULE_W-1:0] rule;
  } ring_ctl_t;

endpackage

`default_nettype wire

[rtl/eca_if.sv]
// Valid/ready channel interfaces of the cellular automaton classifier.
// Depends on eca_pkg for field widths.
`default_nettype none

interface eca_in_if;
  import eca_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PATTERN_W-1:0] start_pattern;
  logic [RULE_W-1:0]    rule_code;
  logic                 first_rule;
  logic                 last_rule;

  modport source (output valid, start_pattern, rule_code, first_rule, last_rule,
                  input ready);
  modport sink   (input valid, start_pattern, rule_code, first_rule, last_rule,
                  output ready);
endinterface

interface eca_out_if;
  logic valid;
  logic ready;
  logic class_bit;

  modport source (output valid, class_bit, input ready);
  modport sink   (input valid, class_bit, output ready);
endinterface

interface eca_cfg_if;
  import eca_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/eca_cell.sv]
// One cell of the automaton ring: a single state bit with its update rule.
// Depends on eca_pkg for the ring control struct.
`default_nettype none

module eca_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire eca_pkg::ring_ctl_t ctl,
  input  wire logic              load_bit,
  input  wire logic              left,
  input  wire logic              right,
  output logic                   q
);
  import eca_pkg::*;

  logic q_r;
  logic q_nxt;

  always_comb begin
    case (ctl.op)
      OP_LOAD: q_nxt = load_bit;
      OP_GEN:  q_nxt = ctl.rule[{left, q_r, right}];
      // Rotation hands each value one place toward cell zero.
      OP_ROT:  q_nxt = right;
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

[rtl/eca_ring.sv]
// Ring of CELLS automaton cells with wraparound neighbor wiring.
// Depends on eca_pkg and eca_cell.
`default_nettype none

module eca_ring #(
  parameter int unsigned CELLS = eca_pkg::CELLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire eca_pkg::ring_ctl_t            ctl,
  input  wire logic [eca_pkg::PATTERN_W-1:0] pattern,
  output logic                               cell0
);
  import eca_pkg::*;

  logic [CELLS-1:0] row;

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic load_bit;

    // Cells beyond the pattern width load as zero.
    if (j < PATTERN_W) begin : g_pat
      assign load_bit = pattern[j];
    end else begin : g_zero
      assign load_bit = 1'b0;
    end

    eca_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .load_bit (load_bit),
      .left     (row[(j + CELLS - 1) % CELLS]),
      .right    (row[(j + 1) % CELLS]),
      .q        (row[j])
    );
  end

  assign cell0 = row[0];

endmodule

`default_nettype wire

[rtl/eca_classify.sv]
// Serial classifier: counts the ones that rotate past cell zero during a scan.
// Depends on eca_pkg for the mode codes.
`default_nettype none

module eca_classify #(
  parameter int unsigned CELLS = eca_pkg::CELLS_DEF
) (
  input  wire logic           clk,
  input  wire logic           step,
  input  wire logic           first,
  input  wire logic           cell_bit,
  input  wire eca_pkg::mode_t mode,
  output logic                class_bit
);
  import eca_pkg::*;

  localparam int unsigned ONES_W = $clog2(CELLS + 1);

  logic [ONES_W-1:0] ones_r;
  logic [ONES_W-1:0] ones_nxt;
  logic              cell0_r;
  logic              cell0_now;
  logic              majority;

  // The first bit of a scan is the original cell zero.
  assign ones_nxt  = first ? ONES_W'(cell_bit) : ONES_W'(ones_r + ONES_W'(cell_bit));
  assign cell0_now = first ? cell_bit : cell0_r;
  assign majority  = {ones_nxt, 1'b0} > (ONES_W + 1)'(CELLS);

  always_ff @(posedge clk) begin
    if (step) begin
      ones_r <= ones_nxt;
      if (first) begin
        cell0_r <= cell_bit;
      end
    end
  end

  always_comb begin
    case (mode)
      MODE_XOR:   class_bit = ones_nxt[0];
      MODE_CELL0: class_bit = cell0_now;
      default:    class_bit = majority;
    endcase
  end

endmodule

`default_nettype wire

[rtl/elementary_ca_classifier_core.sv]
// Elementary cellular automaton classifier, top level.
// Each rule beat runs STEPS-1 generations of the ring; a first-rule beat first loads the
// start pattern. A last-rule beat adds a scan of CELLS rotation steps that moves the row past
// cell zero; its result and readiness for the next beat follow in the cycle after the last
// scan step, which stalls while an earlier result still waits at the output.
// Synchronous active-low reset clears the row, selects majority mode and empties the output.
`default_nettype none

module elementary_ca_classifier_core #(
  parameter int unsigned CELLS = eca_pkg::CELLS_DEF,
  parameter int unsigned STEPS = eca_pkg::STEPS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  eca_in_if.sink     in_ch,
  eca_out_if.source  out_ch,
  eca_cfg_if.sink    cfg_ch
);
  import eca_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned GEN_W  = (STEPS > 2) ? $clog2(STEPS - 1) : 1;
  localparam int unsigned SCAN_W = $clog2(CELLS);
  localparam logic [GEN_W-1:0]  GEN_LAST  = GEN_W'(STEPS - 2);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(CELLS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [GEN_W-1:0]  gen_cnt_r, gen_cnt_nxt;
  logic [SCAN_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [RULE_W-1:0] rule_r;
  logic              last_r;
  mode_t             mode_r;
  logic              out_valid_r, out_valid_nxt;
  logic              class_r;

  logic      in_fire;
  logic      scan_go;
  logic      scan_done;
  logic      cell0;
  logic      class_now;
  ring_ctl_t ctl;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // The final scan step waits while an earlier result still occupies the output.
  assign scan_go   = (state_r == ST_SCAN)
                     && ((scan_cnt_r != SCAN_LAST) || !out_valid_r || out_ch.ready);
  assign scan_done = scan_go && (scan_cnt_r == SCAN_LAST);

  always_comb begin
    ctl.rule = rule_r;
    ctl.op   = OP_HOLD;
    case (state_r)
      ST_IDLE: begin
        ctl.rule = in_ch.rule_code;
        if (in_fire && in_ch.first_rule) begin
          ctl.op = OP_LOAD;
        end
      end
      ST_RUN:  ctl.op = OP_GEN;
      ST_SCAN: ctl.op = scan_go ? OP_ROT : OP_HOLD;
      default: ctl.op = OP_HOLD;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    gen_cnt_nxt  = gen_cnt_r;
    scan_cnt_nxt = scan_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt   = ST_RUN;
          gen_cnt_nxt = '0;
        end
      end
      ST_RUN: begin
        if (gen_cnt_r == GEN_LAST) begin
          state_nxt    = last_r ? ST_SCAN : ST_IDLE;
          scan_cnt_nxt = '0;
        end else begin
          gen_cnt_nxt = gen_cnt_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end else if (scan_go) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (scan_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        mode_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    gen_cnt_r  <= gen_cnt_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    if (in_fire) begin
      rule_r <= in_ch.rule_code;
      last_r <= in_ch.last_rule;
    end
    if (scan_done) begin
      class_r <= class_now;
    end
  end

  eca_ring #(
    .CELLS (CELLS)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .pattern (in_ch.start_pattern),
    .cell0   (cell0)
  );

  eca_classify #(
    .CELLS (CELLS)
  ) u_classify (
    .clk       (clk),
    .step      (scan_go),
    .first     (scan_cnt_r == '0),
    .cell_bit  (cell0),
    .mode      (mode_r),
    .class_bit (class_now)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.class_bit = class_r;

  `ASSERT_NEXT(a_accept_runs, clk, rst_n, in_fire, state_r == ST_RUN,
               "accepted beat did not start the generation run")
  `ASSERT_IMPL(a_gen_range, clk, rst_n, state_r == ST_RUN, gen_cnt_r <= GEN_LAST,
               "generation counter out of range")
  `ASSERT_IMPL(a_scan_range, clk, rst_n, state_r == ST_SCAN, scan_cnt_r <= SCAN_LAST,
               "scan counter out of range")
  `ASSERT_NEXT(a_scan_result, clk, rst_n, scan_done, out_valid_r && (state_r == ST_IDLE),
               "finished scan did not present a result")

endmodule

`default_nettype wire
